@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/imm_pkg.sv @@
// ----------------------------------------------------------------------------
// imm_pkg
// Types and constants of the integer matrix multiply block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package imm_pkg;

   localparam int SUM_W       = 36;
   localparam int CFG_W       = 6;
   localparam int MAX_RESULTS = 32;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // Command codes
   localparam logic [1:0] CMD_LOAD_A  = 2'd0;
   localparam logic [1:0] CMD_LOAD_B  = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;

   // Register indexes (word address)
   localparam logic [1:0] REG_ROWS_A    = 2'd0;
   localparam logic [1:0] REG_INNER_DIM = 2'd1;
   localparam logic [1:0] REG_COLS_B    = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [4:0]         row_index;
      logic [4:0]         col_index;
      logic signed [15:0] elem_value;
   } req_type;

   typedef struct packed {
      logic [4:0]              out_row;
      logic [4:0]              out_col;
      logic signed [SUM_W-1:0] sum_value;
      logic                    last;
   } rsp_type;

endpackage

`default_nettype wire

@@ sv/integer_matrix_multiply_top.sv @@
// ----------------------------------------------------------------------------
// integer_matrix_multiply_top
// Matrix A times matrix B, one product row per compute transfer, built on a
// single multiply-accumulate unit stepped by a small sequencer.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake          | content
//   ---------+-----------+--------------------+-------------------------------
//   req_     | in        | req_valid/stall    | load A, load B or compute row
//   rsp_     | out       | rsp_valid/stall    | one product element per column
//   csr_     | in/out    | APB-style, pready=1| rows_a, inner_dim, cols_b
//
// A load is written as it is accepted. A compute holds req_stall while, for
// each column, the sequencer reads inner_dim terms through the MAC unit, leaves
// the loop, drains multiply and add, and emits one product element.
// rsp_stall holds the output register and pauses the sequencer before each emit.
// Reset clears control state and sets the registers to 1; the element
// memories are not cleared and hold garbage until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module integer_matrix_multiply_top
   import imm_pkg::*;
#(
   parameter int MAX_DIM    = 32,
   parameter int ELEM_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   // Index width of one matrix dimension, counter width that also holds
   // MAX_DIM, and the width of one element memory address.
   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int CNT_W   = $clog2(MAX_DIM + 1);
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int DEPTH   = 1 << ADDR_W;
   localparam int PROD_W  = 2 * ELEM_WIDTH;
   localparam int ACC_W   = PROD_W + IDX_W + 1;
   localparam int CMP_W   = ((ACC_W > SUM_W) ? ACC_W : SUM_W) + 1;
   localparam int COL_LIM = (MAX_DIM < MAX_RESULTS) ? MAX_DIM : MAX_RESULTS;
   localparam logic signed [CMP_W-1:0] SAT_HI = (CMP_W'(1) <<< (SUM_W - 1)) - 1;
   localparam logic signed [CMP_W-1:0] SAT_LO = -(CMP_W'(1) <<< (SUM_W - 1));

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [CFG_W-1:0] rows_a_ff;
   logic [CFG_W-1:0] inner_dim_ff;
   logic [CFG_W-1:0] cols_b_ff;
   logic             csr_write;
   logic [1:0]       csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= CFG_W'(1);
         inner_dim_ff <= CFG_W'(1);
         cols_b_ff    <= CFG_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            REG_ROWS_A:    rows_a_ff    <= csr_pwdata[CFG_W-1:0];
            REG_INNER_DIM: inner_dim_ff <= csr_pwdata[CFG_W-1:0];
            REG_COLS_B:    cols_b_ff    <= csr_pwdata[CFG_W-1:0];
            default:       ;  // drop writes past the register list
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ROWS_A:    csr_prdata = CSR_DATA_W'(rows_a_ff);
         REG_INNER_DIM: csr_prdata = CSR_DATA_W'(inner_dim_ff);
         REG_COLS_B:    csr_prdata = CSR_DATA_W'(cols_b_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // Clamp the sizes to what the memories hold; cols_b also to the most
   // results one compute may emit.
   logic [CNT_W-1:0] nr_cap;
   logic [CNT_W-1:0] nk_cap;
   logic [CNT_W-1:0] nc_cap;

   assign nr_cap = (32'(rows_a_ff) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(rows_a_ff);
   assign nk_cap = (32'(inner_dim_ff) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(inner_dim_ff);
   assign nc_cap = (32'(cols_b_ff) > COL_LIM) ? CNT_W'(COL_LIM) : CNT_W'(cols_b_ff);

   // ------------------------------------------------------------------------
   // Sequencer state and datapath registers
   // ------------------------------------------------------------------------
   state_type               state_ff;
   logic [CNT_W-1:0]        k_ff;        // inner index being read
   logic [CNT_W-1:0]        j_ff;        // product column
   logic [CNT_W-1:0]        nk_ff;
   logic [CNT_W-1:0]        nc_ff;
   logic [4:0]              row_ff;
   logic                    rd_v_ff;     // memory read data valid
   logic                    mul_v_ff;    // product valid
   logic signed [ELEM_WIDTH-1:0] a_q_ff;
   logic signed [ELEM_WIDTH-1:0] b_q_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [ACC_W-1:0]      acc_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_type                 rsp_data_ff;

   logic req_accept;
   logic row_ok;
   logic load_in_range;
   logic issue;
   logic out_free;
   logic col_last;
   logic emit;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign row_ok = (32'(req_data.row_index) < 32'(nr_cap)) && (nc_cap != '0);
   assign load_in_range = (32'(req_data.row_index) < MAX_DIM)
                       && (32'(req_data.col_index) < MAX_DIM);

   // Issue one read pair per cycle while inner terms remain.
   assign issue    = (state_ff == ST_MAC) && (k_ff < nk_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign col_last = (CNT_W'(j_ff + CNT_W'(1)) == nc_ff);

   // Load the output register on an emit; otherwise hold it while stalled.
   assign emit         = (state_ff == ST_EMIT) && out_free;
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   // ------------------------------------------------------------------------
   // Element memories: one write port for loads, one read port for the MAC
   // ------------------------------------------------------------------------
   logic signed [ELEM_WIDTH-1:0] mem_a [DEPTH];
   logic signed [ELEM_WIDTH-1:0] mem_b [DEPTH];
   logic [ADDR_W-1:0]            wr_addr;
   logic [ADDR_W-1:0]            rd_addr_a;
   logic [ADDR_W-1:0]            rd_addr_b;
   logic signed [ELEM_WIDTH-1:0] elem_in;
   logic                         we_a;
   logic                         we_b;

   assign wr_addr   = {IDX_W'(req_data.row_index), IDX_W'(req_data.col_index)};
   assign rd_addr_a = {IDX_W'(row_ff), k_ff[IDX_W-1:0]};
   assign rd_addr_b = {k_ff[IDX_W-1:0], j_ff[IDX_W-1:0]};
   // Wrap or sign-extend the 16-bit load value to the element width.
   assign elem_in   = ELEM_WIDTH'(req_data.elem_value);
   assign we_a = req_accept && load_in_range && (req_data.cmd == CMD_LOAD_A);
   assign we_b = req_accept && load_in_range && (req_data.cmd == CMD_LOAD_B);

   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_a[wr_addr] <= elem_in;
      end
      if (issue) begin
         a_q_ff <= mem_a[rd_addr_a];
      end
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         mem_b[wr_addr] <= elem_in;
      end
      if (issue) begin
         b_q_ff <= mem_b[rd_addr_b];
      end
   end

   // Multiply stage, then accumulate stage. The sum is wide enough that it
   // never wraps; the final value saturates to the result width.
   always_ff @(posedge clock) begin
      if (rd_v_ff) begin
         prod_ff <= a_q_ff * b_q_ff;
      end
   end

   logic signed [CMP_W-1:0] acc_ext;
   logic signed [SUM_W-1:0] sum_sat;

   assign acc_ext = CMP_W'(acc_ff);
   assign sum_sat = (acc_ext > SAT_HI) ? SUM_W'(SAT_HI)
                  : (acc_ext < SAT_LO) ? SUM_W'(SAT_LO)
                  : SUM_W'(acc_ext);

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         j_ff         <= '0;
         nk_ff        <= '0;
         nc_ff        <= '0;
         rd_v_ff      <= 1'b0;
         mul_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_v_ff      <= issue;
         mul_v_ff     <= rd_v_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (mul_v_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept && (req_data.cmd == CMD_COMPUTE) && row_ok) begin
                  row_ff   <= req_data.row_index;
                  nk_ff    <= nk_cap;
                  nc_ff    <= nc_cap;
                  k_ff     <= '0;
                  j_ff     <= '0;
                  acc_ff   <= '0;
                  state_ff <= ST_MAC;
               end
            end
            ST_MAC: begin
               if (issue) begin
                  k_ff <= CNT_W'(k_ff + CNT_W'(1));
               end else begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // Wait for the last product to land in the accumulator.
               if (!rd_v_ff && !mul_v_ff) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_data_ff.out_row   <= row_ff;
                  rsp_data_ff.out_col   <= 5'(j_ff);
                  rsp_data_ff.sum_value <= sum_sat;
                  rsp_data_ff.last      <= col_last;
                  if (col_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     j_ff     <= CNT_W'(j_ff + CNT_W'(1));
                     k_ff     <= '0;
                     acc_ff   <= '0;
                     state_ff <= ST_MAC;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `ASSERT_IMPLY(a_pipe_empty_outside_mac, clock, reset,
      (state_ff == ST_IDLE) || (state_ff == ST_EMIT), !rd_v_ff && !mul_v_ff,
      "MAC pipeline busy outside the accumulate phase")
   `ASSERT_IMPLY(a_col_in_range, clock, reset,
      state_ff != ST_IDLE, (j_ff < nc_ff) && (k_ff <= nk_ff),
      "column or inner counter past its limit")
   `ASSERT_NEXT(a_emit_loads_output, clock, reset,
      (state_ff == ST_EMIT) && out_free, rsp_valid_ff,
      "emit did not load the output register")

endmodule

`default_nettype wire

@@ sim/integer_matrix_multiply_top_tb.sv @@
// ----------------------------------------------------------------------------
// integer_matrix_multiply_top_tb
// Self-checking bench for the integer matrix multiply block: it loads A and B
// elements, requests product rows under several register settings and checks
// each product element against a row-by-row predictor kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_matrix_multiply_top_tb;
   import imm_pkg::*;

   localparam int MAX_DIM          = 32;
   localparam int ELEM_WIDTH       = 16;
   // One full compute: every column runs the inner loop plus pipeline drain.
   localparam int SETTLE_CYCLES    = MAX_DIM * (MAX_DIM + 5) + 64;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT   = 20000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint SUM_MIN = -SUM_MAX - 1;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   integer_matrix_multiply_top #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Bench state
   // -------------------------------------------------------------------------
   // Register copies as the block holds them; only written while it is idle.
   logic [CFG_W-1:0] rows_cfg  = 6'd1;
   logic [CFG_W-1:0] inner_cfg = 6'd1;
   logic [CFG_W-1:0] cols_cfg  = 6'd1;

   // Element stores as the block sees them at each accepted transfer.
   logic signed [ELEM_WIDTH-1:0] a_elems [MAX_DIM][MAX_DIM];
   logic signed [ELEM_WIDTH-1:0] b_elems [MAX_DIM][MAX_DIM];

   // Which elements the stimulus has loaded so far; a product row is only
   // requested once every operand it reads has been loaded.
   bit a_loaded [MAX_DIM][MAX_DIM];
   bit b_loaded [MAX_DIM][MAX_DIM];

   req_type pending_items[$];
   rsp_type expected_products[$];

   int  queued_items      = 0;
   int  accepted_items    = 0;
   int  checked_products  = 0;
   int  checked_rows      = 0;
   int  register_settings = 0;
   int  mismatch_count    = 0;
   int  csr_errors        = 0;
   bit  idle_enabled      = 1'b1;
   bit  long_hold_armed   = 1'b0;
   bit  long_hold_done    = 1'b0;
   int  req_gap           = 0;
   int  stall_left        = 0;
   int  quiet_cycles      = 0;
   rsp_type want;

   function automatic int capped(input logic [CFG_W-1:0] value);
      return (value > MAX_DIM) ? MAX_DIM : int'(value);
   endfunction

   // Product columns per row: capped at the store size and at the result limit.
   function automatic int product_cols();
      int nc;
      nc = capped(cols_cfg);
      return (nc > MAX_RESULTS) ? MAX_RESULTS : nc;
   endfunction

   // -------------------------------------------------------------------------
   // Predictor: apply one accepted transfer, queue the product row it causes
   // -------------------------------------------------------------------------
   function automatic void predict_transfer(input req_type item);
      int      nr;
      int      nk;
      int      nc;
      longint  acc;
      rsp_type product;
      nr = capped(rows_cfg);
      nk = capped(inner_cfg);
      nc = product_cols();
      case (item.cmd)
         CMD_LOAD_A: a_elems[item.row_index][item.col_index] = item.elem_value;
         CMD_LOAD_B: b_elems[item.row_index][item.col_index] = item.elem_value;
         CMD_COMPUTE: begin
            // Row beyond rows_a, or no columns: nothing comes out.
            if (item.row_index < nr) begin
               for (int j = 0; j < nc; j++) begin
                  acc = 0;
                  for (int k = 0; k < nk; k++)
                     acc += longint'(a_elems[item.row_index][k])
                            * longint'(b_elems[k][j]);
                  // Clamp to the 36-bit signed range of the result field.
                  if (acc > SUM_MAX) acc = SUM_MAX;
                  if (acc < SUM_MIN) acc = SUM_MIN;
                  product.out_row   = item.row_index;
                  product.out_col   = 5'(j);
                  product.sum_value = acc[SUM_W-1:0];
                  product.last      = (j == nc - 1);
                  expected_products.push_back(product);
               end
            end
         end
         default: ;  // unused command: ignored
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic void push_item(input logic [1:0] cmd, input logic [4:0] row,
                                     input logic [4:0] col,
                                     input logic signed [15:0] value);
      req_type item;
      item.cmd        = cmd;
      item.row_index  = row;
      item.col_index  = col;
      item.elem_value = value;
      pending_items.push_back(item);
      if (cmd == CMD_LOAD_A) a_loaded[row][col] = 1'b1;
      if (cmd == CMD_LOAD_B) b_loaded[row][col] = 1'b1;
      // Ignored commands do not count toward the stimulus size.
      if (cmd != CMD_UNUSED) queued_items++;
   endfunction

   // Bias element values toward the extremes now and then.
   function automatic logic signed [15:0] pick_elem();
      case ($urandom_range(0, 11))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return -16'sd1;
         3:       return 16'sd0;
         default: return 16'($urandom);
      endcase
   endfunction

   // Load every operand that a compute of this row reads and that was never
   // loaded, so no compute touches an unwritten element.
   function automatic void load_missing_operands(input logic [4:0] row);
      int nk;
      int nc;
      nk = capped(inner_cfg);
      nc = product_cols();
      if (row >= capped(rows_cfg) || nc == 0) return;
      for (int k = 0; k < nk; k++)
         if (!a_loaded[row][k]) push_item(CMD_LOAD_A, row, 5'(k), pick_elem());
      for (int k = 0; k < nk; k++)
         for (int j = 0; j < nc; j++)
            if (!b_loaded[k][j]) push_item(CMD_LOAD_B, 5'(k), 5'(j), pick_elem());
   endfunction

   // Mostly well-formed compute sequences with random operands, the rest
   // loads anywhere in the stores and unused commands.
   function automatic void queue_random(input int count);
      int         target;
      int         pick;
      int         nr;
      int         nk;
      int         nc;
      logic [4:0] row;
      target = queued_items + count;
      nr = capped(rows_cfg);
      nk = capped(inner_cfg);
      nc = product_cols();
      while (queued_items < target) begin
         pick = $urandom_range(0, 9);
         if (pick <= 6) begin
            // Pick an in-range row; now and then any row, so that rows past
            // rows_a show up as well.
            if (pick == 6 || nr == 0) row = 5'($urandom_range(0, 31));
            else row = 5'($urandom_range(0, nr - 1));
            if (nk > 0 && $urandom_range(0, 2) == 0)
               push_item(CMD_LOAD_A, row, 5'($urandom_range(0, nk - 1)), pick_elem());
            if (nk > 0 && nc > 0 && $urandom_range(0, 2) == 0)
               push_item(CMD_LOAD_B, 5'($urandom_range(0, nk - 1)),
                         5'($urandom_range(0, nc - 1)), pick_elem());
            load_missing_operands(row);
            push_item(CMD_COMPUTE, row, 5'($urandom), 16'($urandom));
         end else if (pick <= 8) begin
            push_item((pick == 7) ? CMD_LOAD_A : CMD_LOAD_B, 5'($urandom), 5'($urandom),
                      pick_elem());
         end else begin
            push_item(CMD_UNUSED, 5'($urandom), 5'($urandom), 16'($urandom));
         end
      end
   endfunction

   // Wait until every item is accepted and every product element has come,
   // then give a compute that emits nothing time to finish, and wait again
   // for any product element a late transfer still owes.
   task automatic drain();
      while (pending_items.size() != 0 || req_valid || expected_products.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (pending_items.size() != 0 || req_valid || expected_products.size() != 0)
         @(posedge clock);
   endtask

   // APB write, then read the register back.
   task automatic write_register(input logic [1:0] index, input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(value)) begin
         $error("register %0d readback: expected %0d, got %0d", index, value, csr_prdata);
         csr_errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         REG_ROWS_A:    rows_cfg  = value;
         REG_INNER_DIM: inner_cfg = value;
         REG_COLS_B:    cols_cfg  = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
                            input logic [CFG_W-1:0] cols);
      write_register(REG_ROWS_A, rows);
      write_register(REG_INNER_DIM, inner);
      write_register(REG_COLS_B, cols);
      register_settings++;
   endtask

   // -------------------------------------------------------------------------
   // Request driver: present queued items, with random gaps between them
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_transfer(req_data);
            accepted_items++;
         end
         // Hold the payload while stalled; otherwise advance.
         if (!req_valid || !req_stall) begin
            if (req_gap != 0) begin
               req_valid <= 1'b0;
               req_gap   <= req_gap - 1;
            end else if (pending_items.size() != 0 && idle_enabled &&
                         $urandom_range(0, 7) == 0) begin
               // Start a random gap before the next item.
               req_valid <= 1'b0;
               req_gap   <= $urandom_range(0, 6);
            end else if (pending_items.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result monitor: check each transfer against the oldest expectation and
   // stall the result channel in bursts
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall      <= 1'b0;
         stall_left     <= 0;
         long_hold_done <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_products.size() == 0) begin
               $error("unexpected product element: row %0d col %0d sum %0d",
                      rsp_data.out_row, rsp_data.out_col, rsp_data.sum_value);
               mismatch_count++;
            end else begin
               want = expected_products.pop_front();
               if (rsp_data.out_row !== want.out_row) begin
                  $error("out_row: expected %0d, got %0d", want.out_row, rsp_data.out_row);
                  mismatch_count++;
               end
               if (rsp_data.out_col !== want.out_col) begin
                  $error("out_col: expected %0d, got %0d", want.out_col, rsp_data.out_col);
                  mismatch_count++;
               end
               if (rsp_data.sum_value !== want.sum_value) begin
                  $error("sum_value: expected %0d, got %0d", want.sum_value,
                         rsp_data.sum_value);
                  mismatch_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_data.last);
                  mismatch_count++;
               end
               checked_products++;
               if (want.last) checked_rows++;
            end
         end
         if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (long_hold_armed && !long_hold_done && rsp_valid) begin
            // Hold off long enough for the block to back up into its input.
            rsp_stall      <= 1'b1;
            stall_left     <= LONG_HOLD_CYCLES - 1;
            long_hold_done <= 1'b1;
         end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 6);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run when no transfer happens on either channel
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("no transfer for %0d cycles, %0d product elements outstanding",
                quiet_cycles, expected_products.size());
         $display("integer_matrix_multiply_top_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset sizes (1 x 1 x 1): extremes of the element range, ignored
      // fields of a compute, the unused command, a row past rows_a and loads
      // outside the sizes in use.
      push_item(CMD_LOAD_A, 5'd0, 5'd0, 16'sh8000);
      push_item(CMD_LOAD_B, 5'd0, 5'd0, 16'sh8000);
      push_item(CMD_COMPUTE, 5'd0, 5'd31, -16'sd1);
      push_item(CMD_UNUSED, 5'd31, 5'd31, 16'sh7FFF);
      push_item(CMD_COMPUTE, 5'd31, 5'd0, 16'sd0);
      push_item(CMD_LOAD_A, 5'd31, 5'd31, 16'sh7FFF);
      push_item(CMD_LOAD_B, 5'd31, 5'd31, -16'sd1);
      push_item(CMD_LOAD_A, 5'd1, 5'd0, 16'sd12345);
      push_item(CMD_LOAD_B, 5'd0, 5'd1, -16'sd7);
      push_item(CMD_LOAD_A, 5'd0, 5'd0, 16'sh7FFF);
      push_item(CMD_COMPUTE, 5'd0, 5'd0, 16'sd0);
      push_item(CMD_LOAD_B, 5'd0, 5'd0, 16'sd0);
      push_item(CMD_COMPUTE, 5'd0, 5'd0, 16'sd0);
      drain();

      // Small sizes; stall the result side for a long stretch while the
      // sender keeps offering items.
      configure(6'd4, 6'd3, 6'd5);
      long_hold_armed = 1'b1;
      queue_random(60);
      drain();

      // rows_a at the cap exactly, cols_b past it: full 32-column rows.
      configure(6'd32, 6'd2, 6'd63);
      queue_random(60);
      drain();

      // inner_dim past the cap: a full 32-term sum. Drive it into the clamp
      // with 32 products of the most negative element with itself, and take
      // the largest negative sum on the next row.
      configure(6'd2, 6'd63, 6'd1);
      for (int k = 0; k < MAX_DIM; k++) begin
         push_item(CMD_LOAD_A, 5'd0, 5'(k), 16'sh8000);
         push_item(CMD_LOAD_B, 5'(k), 5'd0, 16'sh8000);
         push_item(CMD_LOAD_A, 5'd1, 5'(k), 16'sh7FFF);
      end
      push_item(CMD_COMPUTE, 5'd0, 5'd0, 16'sd0);
      push_item(CMD_COMPUTE, 5'd1, 5'd0, 16'sd0);
      queue_random(20);
      drain();

      // Zero registers: no rows, no inner terms, no columns.
      configure(6'd0, 6'd3, 6'd3);
      queue_random(15);
      drain();
      configure(6'd3, 6'd0, 6'd4);
      queue_random(20);
      drain();
      configure(6'd3, 6'd3, 6'd0);
      queue_random(15);
      drain();

      // Mid-size; pause the sender halfway until every result is back.
      configure(6'd8, 6'd6, 6'd8);
      queue_random(40);
      drain();
      queue_random(40);
      drain();

      // Last stretch at full rate on both sides.
      idle_enabled = 1'b0;
      configure(6'd5, 6'd4, 6'd6);
      queue_random(60);
      drain();

      $display("covered %0d input transfers over %0d register settings plus reset sizes",
               accepted_items, register_settings);
      $display("checked %0d product elements in %0d rows", checked_products, checked_rows);
      if (mismatch_count == 0 && csr_errors == 0)
         $display("integer_matrix_multiply_top_tb OK");
      else
         $display("integer_matrix_multiply_top_tb NOT OK");
      $finish;
   end

endmodule
